/* src/nsw_pkg.sv */
`default_nettype none

package nsw_pkg;

    // Word codes on the result channel.
    localparam logic [5:0] W_ZERO         = 6'd0;
    localparam logic [5:0] W_TEN          = 6'd10;
    localparam logic [5:0] W_TENS_BASE    = 6'd20;
    localparam logic [5:0] W_HUNDRED      = 6'd28;
    localparam logic [5:0] W_THOUSAND     = 6'd29;
    localparam logic [5:0] W_MINUS        = 6'd30;
    localparam logic [5:0] W_UNKNOWN      = 6'd31;
    localparam logic [5:0] W_ONE_THOUSAND = 6'd32;
    localparam logic [5:0] W_ONE_HUNDRED  = 6'd33;
    localparam logic [5:0] W_SPECIAL_BASE = 6'd34;
    localparam logic [5:0] W_BASE80       = 6'd42;
    localparam logic [5:0] W_BASE60       = 6'd43;
    localparam logic [5:0] W_BASE20S      = 6'd44;
    localparam logic [5:0] W_LAST_CODE    = 6'd44;

    // Largest magnitude that is spoken as digits.
    localparam logic [19:0] MAX_SPOKEN = 20'd99999;

    // Reciprocal for the divide by 1000; exact for magnitudes below 100000.
    localparam int          DIV1000_SHIFT = 27;
    localparam logic [17:0] DIV1000_MUL   = 18'((2 ** DIV1000_SHIFT + 999) / 1000);

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_SINGLE_THOUSAND = 3'd0,
        CFG_SINGLE_HUNDRED  = 3'd1,
        CFG_SPECIAL_ONES    = 3'd2,
        CFG_EIGHTY_BASE     = 3'd3,
        CFG_SIXTY_BASE      = 3'd4,
        CFG_TWENTIES_BASE   = 3'd5
    } t_cfg_idx;

    // A run of up to three words; w[0] is spoken first.
    typedef struct packed {
        logic [1:0]      len;
        logic [2:0][5:0] w;
    } t_seg;

    // Words for a remainder 10*t+u below 100; nothing for zero.
    function automatic t_seg say_rem(
        input logic [3:0] t,
        input logic [3:0] u,
        input logic [7:0] mask,
        input logic       eighty,
        input logic       sixty,
        input logic       twenties
    );
        t_seg       seg;
        logic [2:0] k;
        seg = '0;
        k   = 3'(t - 4'd2);
        if (u == 4'd1 && t >= 4'd2 && mask[k]) begin
            seg.len  = 2'd1;
            seg.w[0] = W_SPECIAL_BASE + 6'(k);
        end else if (eighty && t >= 4'd8) begin
            seg.w[0] = W_BASE80;
            seg.w[1] = (t == 4'd9) ? W_TEN + 6'(u) : 6'(u);
            seg.len  = (t == 4'd9 || u != 4'd0) ? 2'd2 : 2'd1;
        end else if (sixty && (t == 4'd6 || t == 4'd7)) begin
            seg.w[0] = W_BASE60;
            seg.w[1] = (t == 4'd7) ? W_TEN + 6'(u) : 6'(u);
            seg.len  = (t == 4'd7 || u != 4'd0) ? 2'd2 : 2'd1;
        end else if (twenties && t == 4'd2 && u != 4'd0) begin
            seg.len  = 2'd2;
            seg.w[0] = W_BASE20S;
            seg.w[1] = 6'(u);
        end else if (t >= 4'd2) begin
            seg.w[0] = W_TENS_BASE + 6'(t) - 6'd2;
            seg.w[1] = 6'(u);
            seg.len  = (u != 4'd0) ? 2'd2 : 2'd1;
        end else if (t == 4'd1) begin
            seg.len  = 2'd1;
            seg.w[0] = W_TEN + 6'(u);
        end else if (u != 4'd0) begin
            seg.len  = 2'd1;
            seg.w[0] = 6'(u);
        end
        return seg;
    endfunction

endpackage

`default_nettype wire

/* src/number_to_spoken_words_top.sv */
// Spoken-number sequencer.
// Input channel: i_valid / o_stall with i_value, a 20-bit signed reading. An item
// is taken at a clock edge where i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with o_word_code and o_last_word. Each reading yields
// one to eight word items, one per cycle unless stalled; o_last_word marks the final one.
// Configuration: a write of i_cfg_data to register i_cfg_idx when i_cfg_we is
// high; the user must see that registers are changed only while the block is idle;
// the block itself does not enforce this. A reading passes through the seven pipeline
// stages and the serializer register before its first word appears.
// Throughput: the pipeline takes one reading per cycle when not stalled; the word
// serializer holds each reading until its last word is taken, then loads the next.
// Readings queue in the pipeline stages meanwhile.
// Reset (synchronous, active low) empties the pipeline and the serializer and
// clears all configuration registers to 0.
// When the receiver stalls, the current word holds, the serializer stops, and the
// pipeline fills up until o_stall rises; nothing is lost or repeated.
`default_nettype none

module number_to_spoken_words_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [19:0] i_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [5:0]       o_word_code,
    output logic             o_last_word
);
    import nsw_pkg::*;

    // Configuration registers.
    logic       r_single_th;
    logic       r_single_hu;
    logic [7:0] r_special_mask;
    logic       r_eighty;
    logic       r_sixty;
    logic       r_twenties;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_single_th    <= 1'b0;
            r_single_hu    <= 1'b0;
            r_special_mask <= 8'd0;
            r_eighty       <= 1'b0;
            r_sixty        <= 1'b0;
            r_twenties     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SINGLE_THOUSAND: r_single_th    <= i_cfg_data[0];
                CFG_SINGLE_HUNDRED:  r_single_hu    <= i_cfg_data[0];
                CFG_SPECIAL_ONES:    r_special_mask <= i_cfg_data;
                CFG_EIGHTY_BASE:     r_eighty       <= i_cfg_data[0];
                CFG_SIXTY_BASE:      r_sixty        <= i_cfg_data[0];
                CFG_TWENTIES_BASE:   r_twenties     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stage valid bits and the ready chain from the serializer back to the input.
    logic [7:1] r_v;
    logic [8:1] rdy;
    logic       r_busy;
    logic [2:0] r_idx;
    logic [2:0] r_last_idx;
    logic       out_acc;

    assign out_acc = r_busy && !i_stall;
    assign rdy[8]  = !r_busy || (out_acc && r_idx == r_last_idx);
    assign rdy[7]  = !r_v[7] || rdy[8];
    assign rdy[6]  = !r_v[6] || rdy[7];
    assign rdy[5]  = !r_v[5] || rdy[6];
    assign rdy[4]  = !r_v[4] || rdy[5];
    assign rdy[3]  = !r_v[3] || rdy[4];
    assign rdy[2]  = !r_v[2] || rdy[3];
    assign rdy[1]  = !r_v[1] || rdy[2];
    assign o_stall = !rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[1]) r_v[1] <= i_valid;
            if (rdy[2]) r_v[2] <= r_v[1];
            if (rdy[3]) r_v[3] <= r_v[2];
            if (rdy[4]) r_v[4] <= r_v[3];
            if (rdy[5]) r_v[5] <= r_v[4];
            if (rdy[6]) r_v[6] <= r_v[5];
            if (rdy[7]) r_v[7] <= r_v[6];
        end
    end

    // Stage 1: sign, magnitude and the zero and out-of-range flags.
    logic [19:0] n_mag;
    logic        r1_neg;
    logic        r1_zero;
    logic        r1_over;
    logic [16:0] r1_mag;

    assign n_mag = i_value[19] ? (~i_value + 20'd1) : i_value;

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r1_neg  <= i_value[19];
            r1_zero <= (n_mag == 20'd0);
            r1_over <= (n_mag > MAX_SPOKEN);
            r1_mag  <= n_mag[16:0];
        end
    end

    // Stage 2: thousands part by reciprocal multiplication.
    logic [34:0] n_prod_th;
    logic        r2_neg;
    logic        r2_zero;
    logic        r2_over;
    logic [16:0] r2_mag;
    logic [6:0]  r2_th;

    assign n_prod_th = 35'(r1_mag) * 35'(DIV1000_MUL);

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r2_neg  <= r1_neg;
            r2_zero <= r1_zero;
            r2_over <= r1_over;
            r2_mag  <= r1_mag;
            r2_th   <= n_prod_th[DIV1000_SHIFT +: 7];
        end
    end

    // Stage 3: the part below 1000.
    logic [16:0] n_lo;
    logic        r3_neg;
    logic        r3_zero;
    logic        r3_over;
    logic [6:0]  r3_th;
    logic [9:0]  r3_lo;

    assign n_lo = r2_mag - 17'(r2_th) * 17'd1000;

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r3_neg  <= r2_neg;
            r3_zero <= r2_zero;
            r3_over <= r2_over;
            r3_th   <= r2_th;
            r3_lo   <= n_lo[9:0];
        end
    end

    // Stage 4: hundreds digit, tenths of the low part and thousands tens digit.
    logic [15:0] n_prod_hu;
    logic [17:0] n_prod_q;
    logic [14:0] n_prod_tt;
    logic        r4_neg;
    logic        r4_zero;
    logic        r4_over;
    logic [6:0]  r4_th;
    logic [9:0]  r4_lo;
    logic [3:0]  r4_hu;
    logic [6:0]  r4_q;
    logic [3:0]  r4_tt;

    assign n_prod_hu = 16'(r3_lo) * 16'd41;
    assign n_prod_q  = 18'(r3_lo) * 18'd205;
    assign n_prod_tt = 15'(r3_th) * 15'd205;

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r4_neg  <= r3_neg;
            r4_zero <= r3_zero;
            r4_over <= r3_over;
            r4_th   <= r3_th;
            r4_lo   <= r3_lo;
            r4_hu   <= n_prod_hu[15:12];
            r4_q    <= n_prod_q[17:11];
            r4_tt   <= n_prod_tt[14:11];
        end
    end

    // Stage 5: the remaining decimal digits.
    logic [6:0] n_rt;
    logic [9:0] n_ru;
    logic [6:0] n_tu;
    logic       r5_neg;
    logic       r5_zero;
    logic       r5_over;
    logic [3:0] r5_tt;
    logic [3:0] r5_tu;
    logic [3:0] r5_hu;
    logic [3:0] r5_rt;
    logic [3:0] r5_ru;

    assign n_rt = r4_q - 7'(r4_hu) * 7'd10;
    assign n_ru = r4_lo - 10'(r4_q) * 10'd10;
    assign n_tu = r4_th - 7'(r4_tt) * 7'd10;

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r5_neg  <= r4_neg;
            r5_zero <= r4_zero;
            r5_over <= r4_over;
            r5_tt   <= r4_tt;
            r5_tu   <= n_tu[3:0];
            r5_hu   <= r4_hu;
            r5_rt   <= n_rt[3:0];
            r5_ru   <= n_ru[3:0];
        end
    end

    // Stage 6: word runs for thousands, hundreds and remainder.
    t_seg n_th_words;
    t_seg n_seg_a;
    t_seg n_seg_b;
    t_seg n_seg_c;
    logic r6_neg;
    t_seg r6_seg_a;
    t_seg r6_seg_b;
    t_seg r6_seg_c;

    always_comb begin
        n_th_words = say_rem(r5_tt, r5_tu, r_special_mask, r_eighty, r_sixty, r_twenties);
        n_seg_a = '0;
        n_seg_b = '0;
        n_seg_c = say_rem(r5_rt, r5_ru, r_special_mask, r_eighty, r_sixty, r_twenties);

        // Thousands: the single word, or the part followed by thousand.
        if (r5_tt == 4'd0 && r5_tu == 4'd1 && r_single_th) begin
            n_seg_a.len  = 2'd1;
            n_seg_a.w[0] = W_ONE_THOUSAND;
        end else if (r5_tt != 4'd0 || r5_tu != 4'd0) begin
            n_seg_a                  = n_th_words;
            n_seg_a.w[n_th_words.len] = W_THOUSAND;
            n_seg_a.len              = n_th_words.len + 2'd1;
        end

        // Hundreds: the single word, or the digit followed by hundred.
        if (r5_hu == 4'd1 && r_single_hu) begin
            n_seg_b.len  = 2'd1;
            n_seg_b.w[0] = W_ONE_HUNDRED;
        end else if (r5_hu != 4'd0) begin
            n_seg_b.len  = 2'd2;
            n_seg_b.w[0] = 6'(r5_hu);
            n_seg_b.w[1] = W_HUNDRED;
        end

        // Zero and out-of-range readings each say a single word, after minus if negative.
        if (r5_zero || r5_over) begin
            n_seg_a      = '0;
            n_seg_b      = '0;
            n_seg_c      = '0;
            n_seg_c.len  = 2'd1;
            n_seg_c.w[0] = r5_zero ? W_ZERO : W_UNKNOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[6]) begin
            r6_neg   <= r5_neg;
            r6_seg_a <= n_seg_a;
            r6_seg_b <= n_seg_b;
            r6_seg_c <= n_seg_c;
        end
    end

    // Stage 7: pack the runs into one list of up to eight words.
    logic [7:0][5:0] n_list;
    logic [3:0]      n_pos;
    logic [7:0][5:0] r7_list;
    logic [2:0]      r7_last_idx;

    always_comb begin
        n_list = '0;
        n_pos  = 4'd0;
        if (r6_neg) begin
            n_list[0] = W_MINUS;
            n_pos     = 4'd1;
        end
        for (int j = 0; j < 3; j++) begin
            if (2'(j) < r6_seg_a.len) n_list[3'(n_pos) + 3'(j)] = r6_seg_a.w[j];
        end
        n_pos = n_pos + 4'(r6_seg_a.len);
        for (int j = 0; j < 2; j++) begin
            if (2'(j) < r6_seg_b.len) n_list[3'(n_pos) + 3'(j)] = r6_seg_b.w[j];
        end
        n_pos = n_pos + 4'(r6_seg_b.len);
        for (int j = 0; j < 2; j++) begin
            if (2'(j) < r6_seg_c.len) n_list[3'(n_pos) + 3'(j)] = r6_seg_c.w[j];
        end
        n_pos = n_pos + 4'(r6_seg_c.len);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[7]) begin
            r7_list     <= n_list;
            r7_last_idx <= 3'(n_pos - 4'd1);
        end
    end

    // Serializer: one word per accepted output item.
    logic [7:0][5:0] r_list;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (out_acc && r_idx != r_last_idx) begin
            r_idx <= r_idx + 3'd1;
        end else if (rdy[8]) begin
            r_busy <= r_v[7];
            r_idx  <= 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[8]) begin
            r_list     <= r7_list;
            r_last_idx <= r7_last_idx;
        end
    end

    assign o_valid     = r_busy;
    assign o_word_code = r_list[r_idx];
    assign o_last_word = (r_idx == r_last_idx);

    // Reset leaves no word pending.
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // The word index never runs past the end of the list.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx <= r_last_idx)
        else $error("word index beyond list end");

    // A reading's words continue until its last one is taken.
    a_seq_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_word |=> o_valid && r_idx == $past(r_idx) + 3'd1)
        else $error("word sequence broken before its last word");

    // Minus only opens a list, and codes stay in range.
    a_minus_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_word_code <= W_LAST_CODE) && (o_word_code != W_MINUS || r_idx == 3'd0))
        else $error("bad word code or misplaced minus");

endmodule

`default_nettype wire
